@@ src/gpio_register_block_defines.svh @@
// Assertion macros shared by the GPIO register block RTL.
`ifndef GPIO_REGISTER_BLOCK_DEFINES_SVH
`define GPIO_REGISTER_BLOCK_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define GRB_ASSERT_NOW(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("gpio_register_block: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define GRB_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("gpio_register_block: next-cycle check failed");

`endif

@@ src/gpio_rb_pkg.sv @@
package gpio_rb_pkg;

	localparam int PIN_COUNT            = 54;
	localparam int PINS_PER_SELECT_WORD = 10;
	localparam int SELECT_WORDS         = 6;
	localparam int SELECT_IDX_BITS      = $clog2(SELECT_WORDS);
	localparam int FIELD_BITS           = 3;
	localparam int SELECT_BITS          = FIELD_BITS * PINS_PER_SELECT_WORD;
	localparam int DATA_BITS            = 32;
	localparam int OFFSET_BITS          = 6;
	localparam int PULL_BITS            = 2;

	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [PIN_COUNT-1:0]   pins_t;
	typedef logic [SELECT_BITS-1:0] select_t;
	typedef logic [DATA_BITS-1:0]   data_t;
	typedef logic [PULL_BITS-1:0]   pull_t;

	// Register word offsets (byte offset divided by four).
	localparam offset_t OFF_SET0    = offset_t'('h1C >> 2);
	localparam offset_t OFF_SET1    = offset_t'(('h1C >> 2) + 1);
	localparam offset_t OFF_CLR0    = offset_t'('h28 >> 2);
	localparam offset_t OFF_CLR1    = offset_t'(('h28 >> 2) + 1);
	localparam offset_t OFF_LEV0    = offset_t'('h34 >> 2);
	localparam offset_t OFF_LEV1    = offset_t'(('h34 >> 2) + 1);
	localparam offset_t OFF_PUD     = offset_t'('h94 >> 2);
	localparam offset_t OFF_PUDCLK0 = offset_t'('h98 >> 2);
	localparam offset_t OFF_PUDCLK1 = offset_t'(('h98 >> 2) + 1);

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [FIELD_BITS-1:0] FUNC_OUTPUT = 3'b001;
	localparam pull_t PULL_DOWN = 2'd1;
	localparam pull_t PULL_UP   = 2'd2;

	// Bits of select word w that belong to existing pins.
	function automatic select_t select_mask(int w);
		select_t m;
		m = '0;
		for (int f = 0; f < PINS_PER_SELECT_WORD; f++) begin
			if (w * PINS_PER_SELECT_WORD + f < PIN_COUNT) begin
				m[f*FIELD_BITS +: FIELD_BITS] = '1;
			end
		end
		return m;
	endfunction

	// Place a 32-bit bank word onto the pin vector.
	function automatic pins_t bank_bits(logic bank, data_t data);
		logic [2*DATA_BITS-1:0] wide;
		wide = bank ? {data, {DATA_BITS{1'b0}}} : {{DATA_BITS{1'b0}}, data};
		return wide[PIN_COUNT-1:0];
	endfunction

	// Take one 32-bit bank out of the pin vector.
	function automatic data_t bank_read(logic bank, pins_t v);
		logic [2*DATA_BITS-1:0] wide;
		wide = (2*DATA_BITS)'(v);
		return bank ? wide[2*DATA_BITS-1:DATA_BITS] : wide[DATA_BITS-1:0];
	endfunction

endpackage

@@ src/gpio_register_block.sv @@
// Channel  Handshake           Payload
// in       in_valid/in_stall   kind, word_offset, write_data, pin_inputs
// out      out_valid/out_stall read_data, drive_levels, drive_enables,
//                              pull_up_mask, pull_down_mask
//
// One word is accepted per cycle while in_stall is low; its result passes through
// the input register and then the result register.
// The register file is updated at the same edge that loads the result, so a
// following word sees the new contents with no gap.
// arst_n clears the valid flags and the register file: every pin an input, no pull.
// A stalled result holds the input register; in_stall follows it directly.
`include "gpio_register_block_defines.svh"

module gpio_register_block
	import gpio_rb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   kind,
	input  logic [OFFSET_BITS-1:0] word_offset,
	input  logic [DATA_BITS-1:0]   write_data,
	input  logic [PIN_COUNT-1:0]   pin_inputs,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [DATA_BITS-1:0]   read_data,
	output logic [PIN_COUNT-1:0]   drive_levels,
	output logic [PIN_COUNT-1:0]   drive_enables,
	output logic [PIN_COUNT-1:0]   pull_up_mask,
	output logic [PIN_COUNT-1:0]   pull_down_mask
);

	// Input register.
	logic    valid_s1;
	logic    kind_s1;
	offset_t off_s1;
	data_t   wdata_s1;
	pins_t   pins_s1;

	// Register file.
	select_t func_q [SELECT_WORDS];
	pins_t   latch_q;
	pull_t   mode_q;
	pins_t   pudclk_q;
	pull_t   pull_q [PIN_COUNT];

	select_t func_n [SELECT_WORDS];
	pins_t   latch_n;
	pull_t   mode_n;
	pins_t   pudclk_n;
	pull_t   pull_n [PIN_COUNT];

	// Result register.
	logic  out_valid_q;
	data_t rdata_q;
	pins_t levels_q;
	pins_t enables_q;
	pins_t up_q;
	pins_t down_q;

	data_t rdata_n;
	pins_t enables_n;
	pins_t up_n;
	pins_t down_n;

	logic out_load;
	logic advance;
	logic is_write;
	logic [SELECT_IDX_BITS-1:0] sel_idx;
	pins_t pud_sel;
	logic clr_all;

	assign out_load = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_load;
	assign in_stall = valid_s1 && !out_load;
	assign is_write = (kind_s1 == KIND_WRITE);
	assign sel_idx  = off_s1[SELECT_IDX_BITS-1:0];
	assign pud_sel  = bank_bits(off_s1 == OFF_PUDCLK1, wdata_s1);
	assign clr_all  = advance && is_write && (off_s1 == OFF_CLR0) && (&wdata_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1  <= kind;
			off_s1   <= word_offset;
			wdata_s1 <= write_data;
			pins_s1  <= pin_inputs;
		end
	end

	// Decode and read-modify-write of the register file.
	always_comb begin
		for (int w = 0; w < SELECT_WORDS; w++) begin
			func_n[w] = func_q[w];
		end
		for (int p = 0; p < PIN_COUNT; p++) begin
			pull_n[p] = pull_q[p];
		end
		latch_n  = latch_q;
		mode_n   = mode_q;
		pudclk_n = pudclk_q;
		rdata_n  = '0;

		if (off_s1 < offset_t'(SELECT_WORDS)) begin
			if (is_write) begin
				for (int w = 0; w < SELECT_WORDS; w++) begin
					if (sel_idx == SELECT_IDX_BITS'(w)) begin
						func_n[w] = wdata_s1[SELECT_BITS-1:0] & select_mask(w);
					end
				end
			end else begin
				rdata_n = DATA_BITS'(func_q[sel_idx]);
			end
		end else begin
			case (off_s1)
				OFF_SET0, OFF_SET1: begin
					if (is_write) begin
						latch_n = latch_q | bank_bits(off_s1 == OFF_SET1, wdata_s1);
					end
				end
				OFF_CLR0, OFF_CLR1: begin
					if (is_write) begin
						latch_n = latch_q & ~bank_bits(off_s1 == OFF_CLR1, wdata_s1);
					end
				end
				OFF_LEV0, OFF_LEV1: begin
					if (!is_write) begin
						rdata_n = bank_read(off_s1 == OFF_LEV1, pins_s1);
					end
				end
				OFF_PUD: begin
					if (is_write) begin
						mode_n = wdata_s1[PULL_BITS-1:0];
					end else begin
						rdata_n = DATA_BITS'(mode_q);
					end
				end
				OFF_PUDCLK0, OFF_PUDCLK1: begin
					if (is_write) begin
						pudclk_n = (pudclk_q & ~bank_bits(off_s1 == OFF_PUDCLK1, '1))
							| pud_sel;
						// Every pin clocked with a one takes the current pull mode.
						for (int p = 0; p < PIN_COUNT; p++) begin
							if (pud_sel[p]) begin
								pull_n[p] = mode_q;
							end
						end
					end else begin
						rdata_n = bank_read(off_s1 == OFF_PUDCLK1, pudclk_q);
					end
				end
				default: begin
					rdata_n = '0;
				end
			endcase
		end
	end

	// Per-pin views of the updated state.
	for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
		localparam int W = p / PINS_PER_SELECT_WORD;
		localparam int F = p % PINS_PER_SELECT_WORD;
		if (W < SELECT_WORDS) begin : g_sel
			assign enables_n[p] = (func_n[W][F*FIELD_BITS +: FIELD_BITS] == FUNC_OUTPUT);
		end else begin : g_nosel
			assign enables_n[p] = 1'b0;
		end
		assign up_n[p]   = (pull_n[p] == PULL_UP);
		assign down_n[p] = (pull_n[p] == PULL_DOWN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < SELECT_WORDS; w++) begin
				func_q[w] <= '0;
			end
			for (int p = 0; p < PIN_COUNT; p++) begin
				pull_q[p] <= '0;
			end
			latch_q  <= '0;
			mode_q   <= '0;
			pudclk_q <= '0;
		end else if (advance) begin
			for (int w = 0; w < SELECT_WORDS; w++) begin
				func_q[w] <= func_n[w];
			end
			for (int p = 0; p < PIN_COUNT; p++) begin
				pull_q[p] <= pull_n[p];
			end
			latch_q  <= latch_n;
			mode_q   <= mode_n;
			pudclk_q <= pudclk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rdata_q   <= is_write ? '0 : rdata_n;
			levels_q  <= latch_n;
			enables_q <= enables_n;
			up_q      <= up_n;
			down_q    <= down_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = rdata_q;
	assign drive_levels   = levels_q;
	assign drive_enables  = enables_q;
	assign pull_up_mask   = up_q;
	assign pull_down_mask = down_q;

	`GRB_ASSERT_NEXT(a_write_reads_zero, advance && is_write, read_data == '0)
	`GRB_ASSERT_NOW(a_pull_exclusive, out_valid, (pull_up_mask & pull_down_mask) == '0)
	`GRB_ASSERT_NEXT(a_clear_all_low, clr_all, drive_levels[DATA_BITS-1:0] == '0)
	`GRB_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1 && out_valid_q)

endmodule
